// ----- rtl/rjb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rjb_pkg
// Types and codes shared by the jitter reorder buffer modules.
// ----------------------------------------------------------------------------
package rjb_pkg;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_LATE     = 3'd1;
	localparam logic [2:0] ST_OVERFLOW = 3'd2;
	localparam logic [2:0] ST_NOTREADY = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;

	localparam logic [15:0] SEQ_MAX = 16'hFFFF;

	// command passed from front to back
	typedef struct packed {
		logic        op;
		logic [15:0] seq;
		logic        marker;
		logic [31:0] handle;
		logic [15:0] size;
		logic [31:0] now;
		logic        ready;
	} rjb_cmd_t;

	// result item
	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] seq;
		logic        marker;
		logic [31:0] handle;
		logic [15:0] size;
		logic [15:0] lost;
	} rjb_res_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RD,
		BK_EVAL
	} rjb_bk_state_t;

endpackage
`default_nettype wire

// ----- rtl/rjb_cmd_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rjb_cmd_fifo
// Two-entry command queue between the input front and the ring engine.
// ----------------------------------------------------------------------------
module rjb_cmd_fifo import rjb_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire rjb_cmd_t push_data,
	output logic          full,
	input  wire logic     pop,
	output logic          not_empty,
	output rjb_cmd_t      pop_data
);
	rjb_cmd_t   mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign pop_data  = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= push_data;
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (pop && not_empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push && !full} - {1'b0, pop && not_empty};
		end
	end
endmodule
`default_nettype wire

// ----- rtl/rjb_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rjb_front
// Input stage: takes input transactions and packs them as commands.
// ----------------------------------------------------------------------------
module rjb_front import rjb_pkg::*; (
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        operation,
	input  wire logic [15:0] seq_number,
	input  wire logic        marker,
	input  wire logic [31:0] payload_handle,
	input  wire logic [15:0] content_size,
	input  wire logic [31:0] now,
	input  wire logic        playout_ready,
	input  wire logic        q_full,
	output logic             q_push,
	output rjb_cmd_t         q_data
);
	// pack all input fields; the ring engine classifies every command
	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;
	always_comb begin
		q_data.op     = operation;
		q_data.seq    = seq_number;
		q_data.marker = marker;
		q_data.handle = payload_handle;
		q_data.size   = content_size;
		q_data.now    = now;
		q_data.ready  = playout_ready;
	end
endmodule
`default_nettype wire

// ----- rtl/rjb_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rjb_back
// Ring engine: slot memory, write placement and the serial read scan.
// ----------------------------------------------------------------------------
module rjb_back import rjb_pkg::*; #(
	parameter int SLOTS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [15:0] max_delay,
	input  wire logic        q_valid,
	input  wire rjb_cmd_t    q_data,
	output logic             q_pop,
	output logic             res_valid,
	input  wire logic        res_stall,
	output rjb_res_t         res
);
	localparam int AW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [16:0] SLOTS17 = 17'(SLOTS);
	localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
	localparam logic [AW:0] SLOTS_W = (AW+1)'(SLOTS);
	localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

	// entry: seq, marker, handle, size, arrival
	localparam int EW = 16 + 1 + 32 + 16 + 32;
	logic [EW-1:0] mem [SLOTS];
	logic [EW-1:0] rd_s1;
	logic          valid_q [SLOTS];

	logic [AW-1:0] read_slot_q, scan_idx_q;
	logic [CW-1:0] occ_q;
	logic [CW-1:0] cnt_q;
	logic [15:0]   min_seq_q;
	rjb_bk_state_t state_q, state_d;
	rjb_cmd_t      cmd_q;
	logic          res_full_q;

	// write classification
	logic [15:0] anchor;
	logic [15:0] dist_w;
	logic [AW:0] wsum;
	logic [AW-1:0] widx;
	logic        late, ovf;
	always_comb begin
		anchor = (min_seq_q == 16'd0 || q_data.marker) ? q_data.seq : min_seq_q;
		dist_w = q_data.seq - anchor;
		late   = ({1'b0, anchor} + SLOTS17 < {1'b0, SEQ_MAX}) && (q_data.seq < anchor);
		ovf    = (occ_q >= SLOTS_C) || ({1'b0, dist_w} >= SLOTS17);
		wsum   = {1'b0, read_slot_q} + {1'b0, dist_w[AW-1:0]};
		widx   = (wsum >= SLOTS_W) ? AW'(wsum - SLOTS_W) : wsum[AW-1:0];
	end

	// scan entry fields
	logic [15:0] e_seq;
	logic [31:0] e_arr, age;
	logic        e_exp, e_hit, e_val;
	logic [15:0] dist_r;
	logic [AW-1:0] scan_nxt;
	always_comb begin
		e_seq    = rd_s1[EW-1 -: 16];
		e_arr    = rd_s1[31:0];
		age      = cmd_q.now - e_arr;
		e_val    = valid_q[scan_idx_q];
		e_exp    = age > {16'd0, max_delay};
		dist_r   = e_seq - min_seq_q;
		e_hit    = !e_exp && !dist_r[15];
		scan_nxt = (scan_idx_q == LAST_SLOT) ? '0 : scan_idx_q + AW'(1);
	end

	// result words for the accept and scan paths
	rjb_res_t res_acc, res_eval;
	always_comb begin
		res_acc = '0;
		if (q_data.op) res_acc.status = ST_NOTREADY;
		else if (late) res_acc.status = ST_LATE;
		else if (ovf) res_acc.status = ST_OVERFLOW;
		else res_acc.status = ST_OK;
		res_eval = '0;
		if (e_val && e_hit) begin
			res_eval.status = ST_OK;
			res_eval.seq    = e_seq;
			res_eval.marker = rd_s1[80];
			res_eval.handle = rd_s1[79:48];
			res_eval.size   = rd_s1[47:32];
			res_eval.lost   = dist_r;
		end else begin
			res_eval.status = ST_EMPTY;
			res_eval.seq    = min_seq_q;
		end
	end

	logic accept;
	assign accept = q_valid && state_q == BK_IDLE && !res_full_q;
	assign q_pop  = accept;
	assign res_valid = res_full_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE:  if (accept && q_data.op && q_data.ready) state_d = BK_RD;
			BK_RD:    state_d = BK_EVAL;
			BK_EVAL: begin
				if (e_val && e_hit) state_d = BK_IDLE;
				else if (cnt_q == SLOTS_C - CW'(1)) state_d = BK_IDLE;
				else state_d = BK_RD;
			end
			default:  state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else state_q <= state_d;
	end

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (accept && !q_data.op && !late && !ovf)
			mem[widx] <= {q_data.seq, q_data.marker, q_data.handle, q_data.size, q_data.now};
		rd_s1 <= mem[scan_idx_q];
	end

	// control state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) valid_q[i] <= 1'b0;
			read_slot_q <= '0; scan_idx_q <= '0; occ_q <= '0; cnt_q <= '0;
			min_seq_q <= 16'd0; res_full_q <= 1'b0; cmd_q <= '0; res <= '0;
		end else begin
			if (res_full_q && !res_stall) res_full_q <= 1'b0;
			if (accept) begin
				cmd_q <= q_data;
				if (!q_data.op) begin
					min_seq_q  <= anchor;
					res_full_q <= 1'b1;
					res        <= res_acc;
					if (!late && !ovf) begin
						if (!valid_q[widx]) occ_q <= occ_q + CW'(1);
						valid_q[widx] <= 1'b1;
					end
				end else if (!q_data.ready) begin
					res        <= res_acc;
					res_full_q <= 1'b1;
				end else begin
					scan_idx_q <= read_slot_q;
					cnt_q      <= '0;
				end
			end
			if (state_q == BK_EVAL) begin
				if (e_val && e_exp) begin
					valid_q[scan_idx_q] <= 1'b0;
					if (occ_q != '0) occ_q <= occ_q - CW'(1);
				end
				if (e_val && e_hit) begin
					valid_q[scan_idx_q] <= 1'b0;
					if (occ_q != '0) occ_q <= occ_q - CW'(1);
					read_slot_q <= scan_nxt;
					min_seq_q   <= e_seq + 16'd1;
					res_full_q  <= 1'b1;
					res         <= res_eval;
				end else if (cnt_q == SLOTS_C - CW'(1)) begin
					res_full_q <= 1'b1;
					res        <= res_eval;
					if (min_seq_q != 16'd0) min_seq_q <= min_seq_q + 16'd1;
				end else begin
					scan_idx_q <= scan_nxt;
					cnt_q      <= cnt_q + CW'(1);
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/rtp_jitter_reorder_buffer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtp_jitter_reorder_buffer
// Reorder ring of packet descriptors keyed by RTP sequence number.
// ----------------------------------------------------------------------------
// Usage: input transactions (in_valid/in_stall) carry either a packet store
// (operation 0) or a playout read (operation 1). Each produces exactly one
// result transaction on out_valid/out_stall. max_delay must be written via
// cfg_we/cfg_wdata while the block is idle; the block does not enforce it.
// A two-entry command queue parts the input side from the ring engine.
// A store or a not-ready read is answered from the accept step; a ready
// read scans slots one at a time (registered memory read, then evaluate)
// until a hit or until all SLOTS slots have been visited.
// The engine starts a new command once the result register is empty.
// Reset clears all valid bits, pointers, occupancy and the sequence anchor
// at once; max_delay returns to 200. While out_stall is high the result
// holds and the engine waits; input keeps filling the queue until full.
// ----------------------------------------------------------------------------
module rtp_jitter_reorder_buffer import rjb_pkg::*; #(
	parameter int SLOTS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        operation,
	input  wire logic [15:0] seq_number,
	input  wire logic        marker,
	input  wire logic [31:0] payload_handle,
	input  wire logic [15:0] content_size,
	input  wire logic [31:0] now,
	input  wire logic        playout_ready,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [15:0]      out_seq,
	output logic             out_marker,
	output logic [31:0]      out_handle,
	output logic [15:0]      out_size,
	output logic [15:0]      lost_count
);
	logic [15:0] max_delay_q;
	logic        q_full, q_push, q_pop, q_ne;
	rjb_cmd_t    push_data, pop_data;
	rjb_res_t    res;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_delay_q <= 16'd200;
		else if (cfg_we) max_delay_q <= cfg_wdata;
	end

	rjb_front u_front (
		.in_valid, .in_stall, .operation, .seq_number, .marker, .payload_handle,
		.content_size, .now, .playout_ready, .q_full, .q_push, .q_data(push_data)
	);

	rjb_cmd_fifo u_fifo (
		.clk, .arst_n, .push(q_push), .push_data, .full(q_full),
		.pop(q_pop), .not_empty(q_ne), .pop_data
	);

	rjb_back #(.SLOTS(SLOTS)) u_back (
		.clk, .arst_n, .max_delay(max_delay_q), .q_valid(q_ne), .q_data(pop_data),
		.q_pop, .res_valid(out_valid), .res_stall(out_stall), .res
	);

	assign status     = res.status;
	assign out_seq    = res.seq;
	assign out_marker = res.marker;
	assign out_handle = res.handle;
	assign out_size   = res.size;
	assign lost_count = res.lost;
endmodule
`default_nettype wire

// ----- rtl/rjb_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rjb_checker
// Port-level checks of the jitter reorder buffer, bound to the top level.
// ----------------------------------------------------------------------------
module rjb_checker import rjb_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [2:0]  status,
	input wire logic [15:0] out_seq,
	input wire logic [15:0] lost_count,
	input wire logic [31:0] out_handle
);
	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_seq))
		else $error("result changed under stall");

	// status code in range
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_EMPTY)
		else $error("bad status");

	// non-ok results carry no loss count or handle
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> lost_count == 16'd0 && out_handle == 32'd0)
		else $error("stray fields on failed result");
endmodule

bind rtp_jitter_reorder_buffer rjb_checker u_chk (
	.clk, .arst_n, .out_valid, .out_stall, .status, .out_seq, .lost_count, .out_handle
);
`default_nettype wire
